>>> rtl/core/msc_pkg.sv
// Shared types and constants for the MIPS subset core.
// Used by every module under rtl/core except msc_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package msc_pkg;

   localparam int DMEM_WORDS = 1024;
   localparam int DMEM_AW    = $clog2(DMEM_WORDS);
   localparam logic [31:0] DMEM_BYTES      = 32'(DMEM_WORDS * 4);
   localparam logic [31:0] GP_RESET        = 32'h1000_8000;
   localparam logic [31:0] DATA_BASE_RESET = 32'h1000_0000;
   localparam logic [31:0] START_PC_RESET  = 32'h0000_0000;

   localparam int QDEPTH = 2;
   localparam int QAW    = 1;

   localparam logic CSR_START_PC  = 1'b0;
   localparam logic CSR_DATA_BASE = 1'b1;

   localparam logic [1:0] PK_NONE    = 2'd0;
   localparam logic [1:0] PK_NEWLINE = 2'd1;
   localparam logic [1:0] PK_INT     = 2'd2;
   localparam logic [1:0] PK_PROMPT  = 2'd3;

   localparam logic [5:0] OPC_SPECIAL = 6'h00;
   localparam logic [5:0] OPC_J       = 6'h02;
   localparam logic [5:0] OPC_JAL     = 6'h03;
   localparam logic [5:0] OPC_BEQ     = 6'h04;
   localparam logic [5:0] OPC_BNE     = 6'h05;
   localparam logic [5:0] OPC_ADDI    = 6'h08;
   localparam logic [5:0] OPC_ADDIU   = 6'h09;
   localparam logic [5:0] OPC_ANDI    = 6'h0c;
   localparam logic [5:0] OPC_LUI     = 6'h0f;
   localparam logic [5:0] OPC_TRAP    = 6'h1a;
   localparam logic [5:0] OPC_LW      = 6'h23;
   localparam logic [5:0] OPC_SW      = 6'h2b;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_MFHI = 6'h10;
   localparam logic [5:0] FN_MFLO = 6'h12;
   localparam logic [5:0] FN_MULT = 6'h18;
   localparam logic [5:0] FN_DIV  = 6'h1a;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_SLT  = 6'h2a;

   localparam logic [3:0] TRAP_NEWLINE = 4'h0;
   localparam logic [3:0] TRAP_PRINT   = 4'h1;
   localparam logic [3:0] TRAP_READ    = 4'h5;
   localparam logic [3:0] TRAP_EXIT    = 4'ha;

   typedef enum logic [4:0] {
      OP_SLL, OP_SRA, OP_JR, OP_MFHI, OP_MFLO, OP_MULT, OP_DIV, OP_ADDU,
      OP_SUBU, OP_SLT, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ANDI,
      OP_LUI, OP_LW, OP_SW, OP_TNL, OP_TPRINT, OP_TREAD, OP_TEXIT,
      OP_TBAD, OP_BAD
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_MEM, ST_MUL, ST_DIV
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sh;
      logic [15:0] imm;
      logic [25:0] target;
      logic [31:0] console;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

   typedef struct packed {
      logic pop;
      logic ready;
   } back_ctl_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  kind;
      logic [31:0] pval;
      logic        halted;
      logic        unimp;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/core/msc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none
module msc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> rtl/core/msc_front.sv
// Front end: accepts requests, decodes them and holds them in a short queue.
// Depends on msc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [63:0]           req_tdata,
   output msc_pkg::qhead_type         head,
   input  wire msc_pkg::back_ctl_type ctl
);
   import msc_pkg::*;

   item_type       q_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;
   item_type       dec;
   logic           push;
   logic [31:0]    ins;

   assign ins = req_tdata[31:0];

   always_comb begin
      dec.rs      = ins[25:21];
      dec.rt      = ins[20:16];
      dec.rd      = ins[15:11];
      dec.sh      = ins[10:6];
      dec.imm     = ins[15:0];
      dec.target  = ins[25:0];
      dec.console = req_tdata[63:32];
      unique case (ins[31:26])
         OPC_SPECIAL: begin
            unique case (ins[5:0])
               FN_SLL:  dec.op = OP_SLL;
               FN_SRA:  dec.op = OP_SRA;
               FN_JR:   dec.op = OP_JR;
               FN_MFHI: dec.op = OP_MFHI;
               FN_MFLO: dec.op = OP_MFLO;
               FN_MULT: dec.op = OP_MULT;
               FN_DIV:  dec.op = OP_DIV;
               FN_ADDU: dec.op = OP_ADDU;
               FN_SUBU: dec.op = OP_SUBU;
               FN_SLT:  dec.op = OP_SLT;
               default: dec.op = OP_BAD;
            endcase
         end
         OPC_J:     dec.op = OP_J;
         OPC_JAL:   dec.op = OP_JAL;
         OPC_BEQ:   dec.op = OP_BEQ;
         OPC_BNE:   dec.op = OP_BNE;
         OPC_ADDI:  dec.op = OP_ADDI;
         OPC_ADDIU: dec.op = OP_ADDI;
         OPC_ANDI:  dec.op = OP_ANDI;
         OPC_LUI:   dec.op = OP_LUI;
         OPC_LW:    dec.op = OP_LW;
         OPC_SW:    dec.op = OP_SW;
         OPC_TRAP: begin
            unique case (ins[3:0])
               TRAP_NEWLINE: dec.op = OP_TNL;
               TRAP_PRINT:   dec.op = OP_TPRINT;
               TRAP_READ:    dec.op = OP_TREAD;
               TRAP_EXIT:    dec.op = OP_TEXIT;
               default:      dec.op = OP_TBAD;
            endcase
         end
         default: dec.op = OP_BAD;
      endcase
   end

   assign req_tready = (count_ff != (QAW+1)'(QDEPTH)) && ctl.ready;
   assign push       = req_tvalid && req_tready;
   assign head.valid = (count_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = ctl.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/msc_div.sv
// Iterative signed divider, one quotient bit per cycle on magnitudes.
// Depends on msc_pkg only for the house import style.
`timescale 1ns / 1ps
`default_nettype none
module msc_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient,
   output logic [31:0]      remainder
);
   import msc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic        negq_ff, negq_in;
   logic        negr_ff, negr_in;
   logic [32:0] trial;
   logic [32:0] diff;

   assign trial = {r_ff, q_ff[31]};
   assign diff  = trial - {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      if (busy_ff) begin
         if (!diff[32]) begin
            r_in = diff[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend[31] ? -dividend : dividend;
         d_in    = divisor[31] ? -divisor : divisor;
         r_in    = '0;
         negq_in = dividend[31] ^ divisor[31];
         negr_in = dividend[31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
   end

   assign done      = done_ff;
   assign quotient  = negq_ff ? -q_ff : q_ff;
   assign remainder = negr_ff ? -r_ff : r_ff;
endmodule
`default_nettype wire

>>> rtl/core/msc_back.sv
// Back end: architectural state, register file, data memory and execution.
// Depends on msc_pkg, msc_ram and msc_div.
`timescale 1ns / 1ps
`default_nettype none
module msc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire msc_pkg::qhead_type head,
   output msc_pkg::back_ctl_type   ctl,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [31:0]        csr_wdata,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output msc_pkg::result_type     rsp_result
);
   import msc_pkg::*;

   state_type        state_ff, state_in;
   logic [DMEM_AW-1:0] clr_idx_ff, clr_idx_in;
   logic [31:0]      pc_ff, pc_in;
   logic [31:0]      data_base_ff, data_base_in;
   logic [31:0]      r29_init_ff, r29_init_in;
   logic             fresh_ff, fresh_in;
   logic             stopped_ff, stopped_in;
   logic [31:0]      hi_ff, hi_in;
   logic [31:0]      lo_ff, lo_in;
   logic [31:0]      rvalid_ff, rvalid_in;
   item_type         cur_ff, cur_in;
   logic             inrange_ff, inrange_in;
   logic [63:0]      prod_ff, prod_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, res;
   logic             fin;

   logic [31:0]      rf_a_rdata, rf_b_rdata, a, b;
   logic [4:0]       rf_a_raddr, rf_b_raddr;
   logic             wb_en;
   logic [4:0]       wb_addr;
   logic [31:0]      wb_data;

   logic               dm_we;
   logic [DMEM_AW-1:0] dm_waddr, dm_raddr;
   logic [31:0]        dm_wdata, dm_rdata;

   logic        div_start, div_done;
   logic [31:0] div_q, div_r;

   logic [31:0] pc4, simm, npc, addr, off;
   logic [29:0] widx;
   logic        in_range, rsp_free;

   function automatic logic [31:0] reg_init(input logic [4:0] r, input logic [31:0] r29);
      logic [31:0] v;
      v = '0;
      if (r == 5'd28) begin
         v = GP_RESET;
      end else if (r == 5'd29) begin
         v = r29;
      end
      return v;
   endfunction

   msc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock(clock), .we(wb_en), .waddr(wb_addr), .wdata(wb_data),
      .raddr(rf_a_raddr), .rdata(rf_a_rdata)
   );
   msc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock(clock), .we(wb_en), .waddr(wb_addr), .wdata(wb_data),
      .raddr(rf_b_raddr), .rdata(rf_b_rdata)
   );
   msc_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
      .clock(clock), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
      .raddr(dm_raddr), .rdata(dm_rdata)
   );
   msc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(a),
      .divisor(b), .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   assign rf_a_raddr = head.item.rs;
   assign rf_b_raddr = head.item.rt;
   assign a = rvalid_ff[cur_ff.rs] ? rf_a_rdata : reg_init(cur_ff.rs, r29_init_ff);
   assign b = rvalid_ff[cur_ff.rt] ? rf_b_rdata : reg_init(cur_ff.rt, r29_init_ff);

   assign pc4      = pc_ff + 32'd4;
   assign simm     = {{16{cur_ff.imm[15]}}, cur_ff.imm};
   assign addr     = a + simm;
   assign off      = addr - data_base_ff;
   assign widx     = off[31:2];
   assign in_range = widx < 30'(DMEM_WORDS);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      pc_in        = pc_ff;
      data_base_in = data_base_ff;
      r29_init_in  = r29_init_ff;
      fresh_in     = fresh_ff;
      stopped_in   = stopped_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      cur_in       = cur_ff;
      inrange_in   = inrange_ff;
      prod_in      = prod_ff;
      ctl.pop      = 1'b0;
      ctl.ready    = (state_ff != ST_CLEAR);
      fin          = 1'b0;
      res.next_pc  = pc_ff;
      res.kind     = PK_NONE;
      res.pval     = '0;
      res.unimp    = 1'b0;
      wb_en        = 1'b0;
      wb_addr      = cur_ff.rd;
      wb_data      = '0;
      dm_we        = 1'b0;
      dm_waddr     = widx[DMEM_AW-1:0];
      dm_wdata     = b;
      dm_raddr     = widx[DMEM_AW-1:0];
      div_start    = 1'b0;
      npc          = pc4;

      unique case (state_ff)
         ST_CLEAR: begin
            dm_we    = 1'b1;
            dm_waddr = clr_idx_ff;
            dm_wdata = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == DMEM_AW'(DMEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid && rsp_free) begin
               ctl.pop  = 1'b1;
               fresh_in = 1'b0;
               if (stopped_ff) begin
                  fin = 1'b1;
               end else begin
                  cur_in   = head.item;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
            fin      = 1'b1;
            unique case (cur_ff.op)
               OP_SLL:  begin wb_en = 1'b1; wb_data = b << cur_ff.sh; end
               OP_SRA:  begin wb_en = 1'b1; wb_data = 32'($signed(b) >>> cur_ff.sh); end
               OP_JR:   npc = a;
               OP_MFHI: begin wb_en = 1'b1; wb_data = hi_ff; end
               OP_MFLO: begin wb_en = 1'b1; wb_data = lo_ff; end
               OP_MULT: begin
                  fin      = 1'b0;
                  prod_in  = $signed(a) * $signed(b);
                  state_in = ST_MUL;
               end
               OP_DIV: begin
                  if (b == '0) begin
                     lo_in = '1;
                     hi_in = a;
                  end else begin
                     fin       = 1'b0;
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               OP_ADDU: begin wb_en = 1'b1; wb_data = a + b; end
               OP_SUBU: begin wb_en = 1'b1; wb_data = a - b; end
               OP_SLT:  begin
                  wb_en   = 1'b1;
                  wb_data = {31'b0, $signed(a) < $signed(b)};
               end
               OP_J:    npc = {pc4[31:28], cur_ff.target, 2'b00};
               OP_JAL:  begin
                  wb_en   = 1'b1;
                  wb_addr = 5'd31;
                  wb_data = pc4;
                  npc     = {pc4[31:28], cur_ff.target, 2'b00};
               end
               OP_BEQ:  if (a == b) npc = pc4 + {simm[29:0], 2'b00};
               OP_BNE:  if (a != b) npc = pc4 + {simm[29:0], 2'b00};
               OP_ADDI: begin wb_en = 1'b1; wb_addr = cur_ff.rt; wb_data = addr; end
               OP_ANDI: begin
                  wb_en   = 1'b1;
                  wb_addr = cur_ff.rt;
                  wb_data = a & {16'b0, cur_ff.imm};
               end
               OP_LUI:  begin
                  wb_en   = 1'b1;
                  wb_addr = cur_ff.rt;
                  wb_data = {cur_ff.imm, 16'b0};
               end
               OP_LW:   begin
                  fin        = 1'b0;
                  inrange_in = in_range;
                  state_in   = ST_MEM;
               end
               OP_SW:   dm_we = in_range;
               OP_TNL:  res.kind = PK_NEWLINE;
               OP_TPRINT: begin res.kind = PK_INT; res.pval = a; end
               OP_TREAD: begin
                  res.kind = PK_PROMPT;
                  wb_en    = 1'b1;
                  wb_addr  = cur_ff.rt;
                  wb_data  = cur_ff.console;
               end
               OP_TEXIT: stopped_in = 1'b1;
               OP_TBAD: begin res.unimp = 1'b1; stopped_in = 1'b1; end
               default: res.unimp = 1'b1;
            endcase
            pc_in       = npc;
            res.next_pc = npc;
         end
         ST_MEM: begin
            wb_en    = 1'b1;
            wb_addr  = cur_ff.rt;
            wb_data  = inrange_ff ? dm_rdata : '0;
            fin      = 1'b1;
            state_in = ST_IDLE;
         end
         ST_MUL: begin
            hi_in    = prod_ff[63:32];
            lo_in    = prod_ff[31:0];
            fin      = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (div_done) begin
               lo_in    = div_q;
               hi_in    = div_r;
               fin      = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (wb_addr == 5'd0) begin
         wb_en = 1'b0;
      end
      res.halted = stopped_in;

      if (csr_we) begin
         if (csr_index == CSR_START_PC) begin
            if (fresh_ff) begin
               pc_in = csr_wdata;
            end
         end else begin
            data_base_in = csr_wdata;
            if (fresh_ff) begin
               r29_init_in = csr_wdata + DMEM_BYTES;
            end
         end
      end
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      if (wb_en) begin
         rvalid_in[wb_addr] = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fin) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         pc_ff        <= START_PC_RESET;
         data_base_ff <= DATA_BASE_RESET;
         r29_init_ff  <= DATA_BASE_RESET + DMEM_BYTES;
         fresh_ff     <= 1'b1;
         stopped_ff   <= 1'b0;
         hi_ff        <= '0;
         lo_ff        <= '0;
         rvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         pc_ff        <= pc_in;
         data_base_ff <= data_base_in;
         r29_init_ff  <= r29_init_in;
         fresh_ff     <= fresh_in;
         stopped_ff   <= stopped_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff     <= cur_in;
      inrange_ff <= inrange_in;
      prod_ff    <= prod_in;
      if (fin) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
endmodule
`default_nettype wire

>>> rtl/core/mips_subset_core_step_top.sv
// Top level of the MIPS subset core: front end, queue and back end.
// Depends on msc_pkg, msc_front and msc_back.
`timescale 1ns / 1ps
`default_nettype none
// Each request carries one instruction word and returns one response with the
// next fetch address, a console event and status. After reset the data memory
// is cleared one word per cycle, all DMEM_WORDS (1024) words, and no request is
// accepted until that pass ends. Up to two decoded requests wait in a queue in
// front of the execute stage, which reads the register file and then executes;
// lw and mult pass through a further state (ST_MEM or ST_MUL), and div waits in
// ST_DIV for its bit-serial divider unless the divisor is zero. Once an exit or
// unknown trap has stopped the core, every request is answered with the held
// address and the halted flag.
module mips_subset_core_step_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // instr_word, console_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // next_pc, print_value, halted, unimplemented
   output logic [1:0]       rsp_tuser,  // print_kind
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   import msc_pkg::*;

   qhead_type    head;
   back_ctl_type ctl;
   result_type   result;

   msc_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_tdata(req_tdata), .head(head), .ctl(ctl)
   );

   msc_back u_back (
      .clock(clock), .reset(reset), .head(head), .ctl(ctl),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_result(result)
   );

   assign rsp_tdata = {6'b0, result.unimp, result.halted, result.pval, result.next_pc};
   assign rsp_tuser = result.kind;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> head.valid)
      else $error("queue popped while empty");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> head.valid)
      else $error("accepted request missing from queue");

   a_unimp_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65]) |-> (rsp_tuser == PK_NONE))
      else $error("unimplemented response carries a console event");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      !ctl.ready |-> !ctl.pop)
      else $error("request issued during memory clear");
endmodule
`default_nettype wire
